// ----- hdl/tlne_pkg.sv -----
package tlne_pkg;

  // Characters the escaper emits itself or matches on
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_USCORE  = 8'h5F;

  // One job: the results caused by one input item.
  // cnt == 0 is a marker-only job.
  typedef struct packed {
    logic [3:0][7:0] bytes;  // bytes[0] goes out first
    logic [2:0]      cnt;
    logic            pct;    // percent-encode each byte as %hh
    logic            last;   // item ended the name
    logic            bad;    // UTF-8 error marker
  } job_t;

  typedef enum logic [1:0] {
    PH_PERCENT,
    PH_HI,
    PH_LO
  } pct_phase_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h61 + {4'd0, v} - 8'd10);
  endfunction

  function automatic logic ascii_plain(input logic [7:0] b);
    return (b == CH_COLON) || (b == CH_USCORE) ||
           (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
           (b >= 8'h30 && b <= 8'h39);
  endfunction

  function automatic logic escaped_punct(input logic [7:0] b);
    logic r;
    case (b) inside
      8'h7E, 8'h2E, 8'h2D, 8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A,
      8'h2B, 8'h2C, 8'h3B, 8'h3D, 8'h2F, 8'h3F, 8'h23, 8'h40, 8'h25: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic base_range(input logic [20:0] c);
    return (c >= 21'h000C0 && c <= 21'h000D6) || (c >= 21'h000D8 && c <= 21'h000F6) ||
           (c >= 21'h000F8 && c <= 21'h002FF) || (c >= 21'h00370 && c <= 21'h0037D) ||
           (c >= 21'h0037F && c <= 21'h01FFF) || (c >= 21'h0200C && c <= 21'h0200D) ||
           (c >= 21'h02070 && c <= 21'h0218F) || (c >= 21'h02C00 && c <= 21'h02FEF) ||
           (c >= 21'h03001 && c <= 21'h0D7FF) || (c >= 21'h0F900 && c <= 21'h0FDCF) ||
           (c >= 21'h0FDF0 && c <= 21'h0FFFD) || (c >= 21'h10000 && c <= 21'hEFFFF);
  endfunction

  function automatic logic combining_range(input logic [20:0] c);
    return (c == 21'h000B7) || (c >= 21'h00300 && c <= 21'h0036F) ||
           (c >= 21'h0203F && c <= 21'h02040);
  endfunction

endpackage

// ----- hdl/tlne_front.sv -----
module tlne_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        in_byte,
  input  logic              name_last,
  input  logic              accept,
  output tlne_pkg::job_t    job,
  output logic              job_push
);

  logic        at_start, at_start_next;
  logic [1:0]  owed, owed_next;
  logic [2:0]  seq_len, seq_len_next;
  logic [20:0] acc, acc_next;
  logic        lead_first, lead_first_next;
  logic        dropping, dropping_next;
  logic [7:0]  held [4];

  logic        held_we;
  logic [1:0]  held_idx;
  logic [20:0] acc_cont;
  logic [1:0]  owed_dec;
  logic [2:0]  lead_len;
  logic [7:0]  lead_mask;

  // %hh job for a code point, leading zero bytes dropped
  function automatic tlne_pkg::job_t pct_job(input logic [20:0] c);
    tlne_pkg::job_t j;
    j = '0;
    j.pct = 1'b1;
    if (c[20:16] != 5'd0) begin
      j.cnt = 3'd3;
      j.bytes[0] = {3'd0, c[20:16]};
      j.bytes[1] = c[15:8];
      j.bytes[2] = c[7:0];
    end else if (c[15:8] != 8'd0) begin
      j.cnt = 3'd2;
      j.bytes[0] = c[15:8];
      j.bytes[1] = c[7:0];
    end else if (c[7:0] != 8'd0) begin
      j.cnt = 3'd1;
      j.bytes[0] = c[7:0];
    end
    return j;
  endfunction

  always_comb begin
    job             = '0;
    at_start_next   = at_start;
    owed_next       = owed;
    seq_len_next    = seq_len;
    acc_next        = acc;
    lead_first_next = lead_first;
    dropping_next   = dropping;
    held_we         = 1'b0;
    held_idx        = 2'(seq_len - {1'b0, owed});
    acc_cont        = {acc[14:0], in_byte[5:0]};
    owed_dec        = owed - 2'd1;
    lead_len        = 3'd0;
    lead_mask       = 8'h00;

    if (dropping) begin
      // discard to name end
    end else if (owed != 2'd0) begin
      held_we   = 1'b1;
      acc_next  = acc_cont;
      owed_next = owed_dec;
      if (owed_dec == 2'd0) begin
        if (tlne_pkg::base_range(acc_cont) ||
            (!lead_first && tlne_pkg::combining_range(acc_cont))) begin
          job.cnt = seq_len;
          for (int k = 0; k < 4; k++) begin
            job.bytes[k] = (2'(k) == held_idx) ? in_byte : held[k];
          end
        end else begin
          job = pct_job(acc_cont);
        end
      end else if (name_last) begin
        job.bad = 1'b1;
      end
    end else if (!in_byte[7]) begin
      if (tlne_pkg::ascii_plain(in_byte) ||
          (in_byte == tlne_pkg::CH_DOT && !at_start && !name_last)) begin
        job.cnt      = 3'd1;
        job.bytes[0] = in_byte;
      end else if (tlne_pkg::escaped_punct(in_byte)) begin
        job.cnt      = 3'd2;
        job.bytes[0] = tlne_pkg::CH_BSLASH;
        job.bytes[1] = in_byte;
      end else begin
        job = pct_job({13'd0, in_byte});
      end
      at_start_next = 1'b0;
    end else begin
      if (in_byte[7:3] == 5'b11110) begin
        lead_len  = 3'd4;
        lead_mask = 8'h07;
      end else if (in_byte[7:4] == 4'b1110) begin
        lead_len  = 3'd3;
        lead_mask = 8'h0F;
      end else if (in_byte[7:5] == 3'b110) begin
        lead_len  = 3'd2;
        lead_mask = 8'h1F;
      end
      if (lead_len == 3'd0) begin
        job.bad       = 1'b1;
        dropping_next = 1'b1;
      end else begin
        held_we         = 1'b1;
        held_idx        = 2'd0;
        acc_next        = {13'd0, in_byte & lead_mask};
        seq_len_next    = lead_len;
        owed_next       = 2'(lead_len - 3'd1);
        lead_first_next = at_start;
        at_start_next   = 1'b0;
        if (name_last) begin
          job.bad = 1'b1;
        end
      end
    end

    job.last = name_last;
    if (name_last) begin
      at_start_next = 1'b1;
      owed_next     = 2'd0;
      seq_len_next  = 3'd0;
      acc_next      = 21'd0;
      dropping_next = 1'b0;
    end

    job_push = accept && (job.cnt != 3'd0 || name_last || job.bad);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_start   <= 1'b1;
      owed       <= 2'd0;
      seq_len    <= 3'd0;
      acc        <= 21'd0;
      lead_first <= 1'b0;
      dropping   <= 1'b0;
    end else if (accept) begin
      at_start   <= at_start_next;
      owed       <= owed_next;
      seq_len    <= seq_len_next;
      acc        <= acc_next;
      lead_first <= lead_first_next;
      dropping   <= dropping_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && held_we) begin
      held[held_idx] <= in_byte;
    end
  end

endmodule

// ----- hdl/tlne_queue.sv -----
module tlne_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  tlne_pkg::job_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output tlne_pkg::job_t rd_data,
  output logic           empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tlne_pkg::job_t slots [DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  logic           do_wr, do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// ----- hdl/tlne_back.sv -----
module tlne_back (
  input  logic           clk,
  input  logic           rst,
  input  tlne_pkg::job_t q_data,
  input  logic           q_empty,
  output logic           q_pop,
  input  logic           pop,
  output logic           empty,
  output logic [7:0]     out_byte,
  output logic           has_byte,
  output logic           run_last,
  output logic           name_end,
  output logic           bad_utf8
);

  logic                 out_valid;
  logic [1:0]           bi, bi_next;
  tlne_pkg::pct_phase_t ph, ph_next;
  logic                 load;
  logic [7:0]           sel, cur_byte;
  logic                 fin;

  assign empty = !out_valid;
  assign load  = !q_empty && (!out_valid || pop);
  assign q_pop = load && fin;

  always_comb begin
    sel = q_data.bytes[bi];
    cur_byte = sel;
    if (q_data.pct) begin
      unique case (ph)
        tlne_pkg::PH_PERCENT: cur_byte = tlne_pkg::CH_PERCENT;
        tlne_pkg::PH_HI:      cur_byte = tlne_pkg::hex_digit(sel[7:4]);
        tlne_pkg::PH_LO:      cur_byte = tlne_pkg::hex_digit(sel[3:0]);
        default:              cur_byte = sel;
      endcase
    end
    fin = (q_data.cnt == 3'd0) ||
          (({1'b0, bi} == q_data.cnt - 3'd1) && (!q_data.pct || ph == tlne_pkg::PH_LO));

    bi_next = bi;
    ph_next = ph;
    if (fin) begin
      bi_next = 2'd0;
      ph_next = tlne_pkg::PH_PERCENT;
    end else if (q_data.pct) begin
      unique case (ph)
        tlne_pkg::PH_PERCENT: ph_next = tlne_pkg::PH_HI;
        tlne_pkg::PH_HI:      ph_next = tlne_pkg::PH_LO;
        default: begin
          ph_next = tlne_pkg::PH_PERCENT;
          bi_next = bi + 2'd1;
        end
      endcase
    end else begin
      bi_next = bi + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      bi        <= 2'd0;
      ph        <= tlne_pkg::PH_PERCENT;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        bi        <= bi_next;
        ph        <= ph_next;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      has_byte <= (q_data.cnt != 3'd0);
      out_byte <= (q_data.cnt != 3'd0) ? cur_byte : 8'h00;
      run_last <= fin;
      name_end <= fin && q_data.last;
      bad_utf8 <= fin && q_data.bad;
    end
  end

endmodule

// ----- hdl/turtle_local_name_escape.sv -----
// Channel   Handshake          Payload
// input     push / full        in_byte[7:0], name_last
// result    empty / pop        out_byte[7:0], has_byte, run_last, name_end, bad_utf8
//
// One input byte is taken per cycle while the job queue has room; its results
// leave one per cycle while the result register is free or popped, so a byte that
// expands (backslash: 2, %hh: up to 9) holds the back end and fills the queue.
// Reset (synchronous) empties the queue and the result register, and puts the
// decoder back at the start of a name. No clearing pass is needed.
module turtle_local_name_escape #(
  parameter int JOB_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       name_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       run_last,
  output logic       name_end,
  output logic       bad_utf8
);

  tlne_pkg::job_t fe_job, q_job;
  logic           fe_push;
  logic           accept;
  logic           q_empty, q_pop;

  // Front: UTF-8 decode and classification, one job per byte at most.
  assign accept = push && !full;

  tlne_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_byte  (in_byte),
    .name_last(name_last),
    .accept   (accept),
    .job      (fe_job),
    .job_push (fe_push)
  );

  // Short queue of jobs decouples decode from expansion.
  tlne_queue #(
    .DEPTH(JOB_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (fe_push),
    .wr_data(fe_job),
    .full   (full),
    .rd_en  (q_pop),
    .rd_data(q_job),
    .empty  (q_empty)
  );

  // Back: walks each job out, one item a cycle while the result is free or popped.
  tlne_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_job),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .out_byte(out_byte),
    .has_byte(has_byte),
    .run_last(run_last),
    .name_end(name_end),
    .bad_utf8(bad_utf8)
  );

  // Error is only ever reported on a marker
  a_bad_is_marker: assert property (@(posedge clk) disable iff (rst)
    (!empty && bad_utf8) |-> !has_byte)
    else $error("bad_utf8 on a data item");

  // Name end closes the run of its byte
  a_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    (!empty && name_end) |-> run_last)
    else $error("name_end without run_last");

  // A marker is always alone and last for its byte
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && !has_byte) |-> (run_last && out_byte == 8'h00))
    else $error("marker not closing its run");

  // Queue holds back the input only when the back end has work
  a_full_busy: assert property (@(posedge clk) disable iff (rst)
    full |-> !empty)
    else $error("front stalled with idle output");

endmodule
